// ----- rtl/pcg_pkg.sv -----
package pcg_pkg;

  localparam logic [63:0] LcgMult    = 64'd6364136223846793005;
  localparam logic [63:0] ResetState = 64'h853c49e6748fea9b;
  localparam logic [63:0] ResetInc   = 64'hda3e39cb94b95bdb;

  localparam logic [3:0] ModeReseed = 4'd0;
  localparam logic [3:0] ModeRaw32  = 4'd1;
  localparam logic [3:0] ModeRaw64  = 4'd2;
  localparam logic [3:0] ModeFast   = 4'd3;
  localparam logic [3:0] ModeExact  = 4'd4;
  localparam logic [3:0] ModeFlt01  = 4'd5;
  localparam logic [3:0] ModeFlt11  = 4'd6;
  localparam logic [3:0] ModeDbl01  = 4'd7;
  localparam logic [3:0] ModeDbl11  = 4'd8;
  localparam logic [3:0] ModeProb   = 4'd9;

  localparam int DivSteps = 32;

  typedef enum logic [8:0] {
    StIdle = 9'b000000001,
    StClr  = 9'b000000010,
    StMul  = 9'b000000100,
    StAdv  = 9'b000001000,
    StSeed = 9'b000010000,
    StRmul = 9'b000100000,
    StRchk = 9'b001000000,
    StDiv  = 9'b010000000,
    StFin  = 9'b100000000
  } ctrl_state_e;

  typedef struct packed {
    logic load_in;
    logic clr;
    logic mul;
    logic adv;
    logic cap_hi;
    logic seed;
    logic rmul;
    logic div_start;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [3:0] mode;
    logic       m_lt_range;
    logic       m_lt_t;
  } sts_t;

  // XSH-RR output permutation of the old state.
  function automatic logic [31:0] xsh_rr(input logic [63:0] s);
    logic [63:0] x;
    logic [31:0] xs;
    logic [4:0]  rot;
    logic [4:0]  lrot;
    x    = (s ^ (s >> 18)) >> 27;
    xs   = x[31:0];
    rot  = s[63:59];
    lrot = 5'd0 - rot;
    return (xs >> rot) | (xs << lrot);
  endfunction

endpackage

// ----- rtl/pcg_if.sv -----
interface pcg_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         mode;
  logic signed [31:0] low_bound;
  logic signed [31:0] high_bound;
  logic [23:0]        threshold;
  modport source(output valid, mode, low_bound, high_bound, threshold, input ready);
  modport sink(input valid, mode, low_bound, high_bound, threshold, output ready);
endinterface

interface pcg_out_if;
  logic               valid;
  logic               ready;
  logic [63:0]        raw_bits;
  logic signed [31:0] int_value;
  logic [51:0]        fraction;
  logic               negative;
  logic               hit;
  modport source(output valid, raw_bits, int_value, fraction, negative, hit, input ready);
  modport sink(input valid, raw_bits, int_value, fraction, negative, hit, output ready);
endinterface

// ----- rtl/pcg32_random_unit_core.sv -----
// Channel   Dir  Payload
// in_i      in   mode, low_bound, high_bound, threshold
// out_o     out  raw_bits, int_value, fraction, negative, hit
// apb       in   seed_value at 0x0, stream_id at 0x8 (64-bit data)
//
// Each generator step forms three registered 32x32 products, then the sum with
// the increment. Exact uniform adds a remainder computation and a redraw for
// every rejected word.
// Reset is asynchronous active low and restores the fixed start state.
// A finished word waits in the output register; the next word is accepted
// meanwhile and stalls only when its own result is ready to leave.
module pcg32_random_unit_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcg_in_if.sink      in_i,
  pcg_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import pcg_pkg::*;

  logic [63:0] seed_q;
  logic [62:0] stream_q;
  cmd_t        cmd;
  sts_t        sts;
  logic        in_ready;
  logic        out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= '0;
      stream_q <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[3]) begin
        stream_q <= pwdata[62:0];
      end else begin
        seed_q <= pwdata;
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[3] ? {1'b0, stream_q} : seed_q;

  pcg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pcg_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .mode_i       (in_i.mode),
    .low_bound_i  (in_i.low_bound),
    .high_bound_i (in_i.high_bound),
    .threshold_i  (in_i.threshold),
    .seed_i       (seed_q),
    .stream_i     (stream_q),
    .raw_bits_o   (out_o.raw_bits),
    .int_value_o  (out_o.int_value),
    .fraction_o   (out_o.fraction),
    .negative_o   (out_o.negative),
    .hit_o        (out_o.hit)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("accepted word did not leave idle");

  a_neg_no_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.negative) |-> (out_o.raw_bits == 64'd0))
    else $error("sign flag set alongside raw output");

  a_int_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.int_value != 32'sd0)) |->
    ((out_o.fraction == 52'd0) && (out_o.raw_bits == 64'd0)))
    else $error("bounded integer mixed with other results");

endmodule

// ----- rtl/pcg_ctrl.sv -----
module pcg_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  pcg_pkg::sts_t sts_i,
  output pcg_pkg::cmd_t cmd_o
);
  import pcg_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        phase_q, phase_d;
  logic        tdone_q, tdone_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        oval_q, oval_d;
  logic        wide;
  // Mode of a newly accepted word is visible next cycle; dispatch from a
  // pending flag keeps the decode on registered data.
  logic        disp_q;

  assign wide = (sts_i.mode == ModeRaw64) || (sts_i.mode == ModeDbl01) ||
                (sts_i.mode == ModeDbl11);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    tdone_d = tdone_q;
    cnt_d   = cnt_q;
    oval_d  = oval_q;
    cmd_o   = '0;
    if (out_ready_i) begin
      oval_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (disp_q) begin
          // Route a freshly accepted word by its mode.
          if (sts_i.mode == ModeReseed) begin
            state_d = StClr;
          end else if (sts_i.mode <= ModeProb) begin
            state_d = StMul;
          end else begin
            state_d = StFin;
          end
        end else if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          phase_d = 1'b0;
          tdone_d = 1'b0;
        end
      end
      StClr: begin
        cmd_o.clr = 1'b1;
        state_d   = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StAdv;
      end
      StAdv: begin
        cmd_o.adv = 1'b1;
        if (sts_i.mode == ModeReseed) begin
          phase_d = 1'b1;
          state_d = phase_q ? StFin : StSeed;
        end else if (wide && !phase_q) begin
          cmd_o.cap_hi = 1'b1;
          phase_d = 1'b1;
          state_d = StMul;
        end else if ((sts_i.mode == ModeFast) || (sts_i.mode == ModeExact)) begin
          state_d = StRmul;
        end else begin
          state_d = StFin;
        end
      end
      StSeed: begin
        cmd_o.seed = 1'b1;
        state_d    = StMul;
      end
      StRmul: begin
        cmd_o.rmul = 1'b1;
        state_d    = (sts_i.mode == ModeExact) ? StRchk : StFin;
      end
      StRchk: begin
        // Rejection: the modulo threshold is formed once, then words are redrawn.
        if (!sts_i.m_lt_range) begin
          state_d = StFin;
        end else if (!tdone_q) begin
          cmd_o.div_start = 1'b1;
          cnt_d   = '0;
          state_d = StDiv;
        end else if (sts_i.m_lt_t) begin
          state_d = StMul;
        end else begin
          state_d = StFin;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(DivSteps - 1)) begin
          tdone_d = 1'b1;
          state_d = StRchk;
        end
      end
      StFin: begin
        if (!oval_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          oval_d  = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      phase_q <= 1'b0;
      tdone_q <= 1'b0;
      cnt_q   <= '0;
      oval_q  <= 1'b0;
      disp_q  <= 1'b0;
    end else begin
      disp_q  <= cmd_o.load_in;
      phase_q <= phase_d;
      tdone_q <= tdone_d;
      cnt_q   <= cnt_d;
      oval_q  <= oval_d;
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle) && !disp_q;
  assign out_valid_o = oval_q;

endmodule

// ----- rtl/pcg_dp.sv -----
module pcg_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pcg_pkg::cmd_t      cmd_i,
  output pcg_pkg::sts_t      sts_o,
  input  logic [3:0]         mode_i,
  input  logic signed [31:0] low_bound_i,
  input  logic signed [31:0] high_bound_i,
  input  logic [23:0]        threshold_i,
  input  logic [63:0]        seed_i,
  input  logic [62:0]        stream_i,
  output logic [63:0]        raw_bits_o,
  output logic signed [31:0] int_value_o,
  output logic [51:0]        fraction_o,
  output logic               negative_o,
  output logic               hit_o
);
  import pcg_pkg::*;

  logic [63:0] gen_q, inc_q;
  logic [3:0]  mode_q;
  logic [31:0] lo_q, hb_q;
  logic [23:0] thr_q;
  logic [63:0] p0_q;
  logic [31:0] p1_q, p2_q;
  logic [31:0] word_q, whi_q;
  logic [63:0] m_q;
  logic [31:0] rem_q, dvd_q;
  logic [31:0] range;
  logic [63:0] pa, pb, pc;
  logic [32:0] trial;
  logic [31:0] r_int;
  logic [63:0] r_raw, wide;
  logic [51:0] r_frac;
  logic        r_neg, r_hit;

  assign range = hb_q - lo_q;
  assign pa    = gen_q[31:0] * LcgMult[31:0];
  assign pb    = 64'(gen_q[31:0] * LcgMult[63:32]);
  assign pc    = 64'(gen_q[63:32] * LcgMult[31:0]);
  assign trial = {rem_q, dvd_q[31]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= ResetState;
      inc_q <= ResetInc;
    end else if (cmd_i.clr) begin
      gen_q <= '0;
      inc_q <= {stream_i, 1'b1};
    end else if (cmd_i.adv) begin
      gen_q <= p0_q + {p1_q + p2_q, 32'd0} + inc_q;
    end else if (cmd_i.seed) begin
      gen_q <= gen_q + seed_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q <= mode_i;
      lo_q   <= low_bound_i;
      hb_q   <= high_bound_i;
      thr_q  <= threshold_i;
    end
    if (cmd_i.mul) begin
      p0_q <= pa;
      p1_q <= pb[31:0];
      p2_q <= pc[31:0];
    end
    if (cmd_i.adv) begin
      word_q <= xsh_rr(gen_q);
    end
    if (cmd_i.cap_hi) begin
      whi_q <= xsh_rr(gen_q);
    end
    if (cmd_i.rmul) begin
      m_q <= word_q * range;
    end
    // Restoring remainder of (2^32 - range) by range, one bit a cycle.
    if (cmd_i.div_start) begin
      rem_q <= '0;
      dvd_q <= 32'd0 - range;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[30:0], 1'b0};
      if (trial >= {1'b0, range}) begin
        rem_q <= 32'(trial - {1'b0, range});
      end else begin
        rem_q <= trial[31:0];
      end
    end
    if (cmd_i.load_out) begin
      raw_bits_o  <= r_raw;
      int_value_o <= r_int;
      fraction_o  <= r_frac;
      negative_o  <= r_neg;
      hit_o       <= r_hit;
    end
  end

  assign wide = {whi_q, word_q};

  always_comb begin
    r_raw  = '0;
    r_int  = '0;
    r_frac = '0;
    r_neg  = 1'b0;
    r_hit  = 1'b0;
    case (mode_q)
      ModeRaw32: r_raw = {32'd0, word_q};
      ModeRaw64: r_raw = wide;
      ModeFast, ModeExact: r_int = lo_q + m_q[63:32];
      ModeFlt01: r_frac = {29'd0, word_q[31:9]};
      ModeFlt11: begin
        r_frac = {29'd0, word_q[31:9]};
        r_neg  = word_q[0];
      end
      ModeDbl01: r_frac = wide[63:12];
      ModeDbl11: begin
        r_frac = wide[63:12];
        r_neg  = word_q[0];
      end
      ModeProb: begin
        r_frac = {29'd0, word_q[31:9]};
        r_hit  = {1'b0, word_q[31:9]} < thr_q;
      end
      default: r_raw = '0;
    endcase
  end

  assign sts_o.mode       = mode_q;
  assign sts_o.m_lt_range = m_q[31:0] < range;
  assign sts_o.m_lt_t     = m_q[31:0] < rem_q;

endmodule
